// File: rtl/utf8_to_unicode_bytes_core_defines.svh
// assertion macros for the checker file of the utf8 decoder
// depends on nothing; included by bare file name
`ifndef UTF8_TO_UNICODE_BYTES_CORE_DEFINES_SVH
`define UTF8_TO_UNICODE_BYTES_CORE_DEFINES_SVH

// clocked check, switched off while reset is asserted
`define U2UB_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// clocked check that also holds through reset
`define U2UB_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: rtl/u2ub_pkg.sv
// constants for the utf8 to big-endian unicode byte decoder
// no dependencies; used by the core and its checker
package u2ub_pkg;

  localparam int unsigned MAX_GROUP = 3;

  // byte codes on the result channel
  localparam logic [7:0] ASCII_HI = 8'h00;
  localparam logic [7:0] TERM_HI  = 8'hFF;
  localparam logic [7:0] TERM_LO  = 8'hFE;
  localparam logic [7:0] ERR_BYTE = 8'h00;
  localparam logic [7:0] END_BYTE = 8'h00;

  // utf8 tag bits
  localparam logic [1:0] CONT_TAG  = 2'b10;
  localparam logic [2:0] LEAD2_TAG = 3'b110;
  localparam logic [3:0] LEAD3_TAG = 4'b1110;
  localparam logic [4:0] LEAD4_TAG = 5'b11110;

  // continuation bytes still expected
  localparam logic [1:0] PEND_IDLE = 2'd0;
  localparam logic [1:0] PEND_ONE  = 2'd1;
  localparam logic [1:0] PEND_TWO  = 2'd2;
  localparam logic [1:0] PEND_THREE = 2'd3;

  // result group made from one input item
  typedef struct packed {
    logic [1:0]                 cnt;
    logic [MAX_GROUP-1:0][7:0]  data;   // data[0] goes out first
    logic                       last;   // final byte of group carries is_last
    logic                       err;
  } grp_t;

endpackage

// File: rtl/utf8_to_unicode_bytes_core.sv
// utf8 to big-endian unicode byte decoder, top level
// depends on u2ub_pkg
//
// - input channel in_valid / in_stall / in_byte: one utf8 byte per item,
//   a zero byte ends the string
// - result channel out_valid / out_stall / out_byte, out_is_last,
//   out_error: one unicode byte per item, most significant first
// - each input byte makes zero to three result bytes: lead and middle
//   bytes none, ascii, end of string and two or three byte sequences two,
//   a four byte sequence three, a bad byte one error item
// - the first result byte of an input byte passes the group register and
//   then the output register on its way to the outputs
// - a new input byte can be taken while the last byte of the previous
//   group leaves, so the single result port sets the input rate
// - in_stall stays high while the group register still holds more than
//   the byte leaving this cycle; a result stall freezes the output
//   register and so backs up into the input
// - synchronous reset (rst_n low) empties both registers and returns
//   the decoder to idle with no partial sequence
module utf8_to_unicode_bytes_core (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_byte,
  output logic       out_is_last,
  output logic       out_error
);
  import u2ub_pkg::*;

  // decoder state
  logic [20:0] code_r, code_nxt;
  logic [1:0]  pend_r, pend_nxt;
  logic        four_r, four_nxt;

  // group register between decoder and output register
  grp_t grp_r, grp_nxt, dec;

  // output register
  logic       out_valid_r, out_valid_nxt;
  logic [7:0] out_byte_r, out_byte_nxt;
  logic       out_last_r, out_last_nxt;
  logic       out_err_r, out_err_nxt;

  logic        out_load;
  logic        in_acc;
  logic [20:0] code_sh;

  // output register takes a new byte whenever it is empty or drained
  assign out_load = !out_valid_r || !out_stall;
  // room for a new group once the last held byte leaves
  assign in_stall = (grp_r.cnt != 2'd0) && !((grp_r.cnt == 2'd1) && out_load);
  assign in_acc   = in_valid && !in_stall;

  // code point with the next six payload bits shifted in
  assign code_sh = {code_r[14:0], in_byte[5:0]};

  // decode one byte into its result group and next state
  always_comb begin
    dec      = '0;
    code_nxt = code_r;
    pend_nxt = pend_r;
    four_nxt = four_r;
    if (pend_r != PEND_IDLE) begin
      if (in_byte[7:6] != CONT_TAG) begin
        // broken sequence: one error byte, back to idle
        dec.cnt     = 2'd1;
        dec.data[0] = ERR_BYTE;
        dec.last    = 1'b1;
        dec.err     = 1'b1;
        code_nxt    = '0;
        pend_nxt    = PEND_IDLE;
        four_nxt    = 1'b0;
      end else begin
        code_nxt = code_sh;
        pend_nxt = pend_r - 2'd1;
        if (pend_r == PEND_ONE) begin
          code_nxt = '0;
          four_nxt = 1'b0;
          if (four_r) begin
            dec.cnt     = 2'd3;
            dec.data[0] = {3'b000, code_sh[20:16]};
            dec.data[1] = code_sh[15:8];
            dec.data[2] = code_sh[7:0];
          end else begin
            dec.cnt     = 2'd2;
            dec.data[0] = code_sh[15:8];
            dec.data[1] = code_sh[7:0];
          end
        end
      end
    end else if (in_byte == END_BYTE) begin
      dec.cnt     = 2'd2;
      dec.data[0] = TERM_HI;
      dec.data[1] = TERM_LO;
      dec.last    = 1'b1;
    end else if (!in_byte[7]) begin
      dec.cnt     = 2'd2;
      dec.data[0] = ASCII_HI;
      dec.data[1] = in_byte;
    end else if (in_byte[7:5] == LEAD2_TAG) begin
      code_nxt = {16'd0, in_byte[4:0]};
      pend_nxt = PEND_ONE;
      four_nxt = 1'b0;
    end else if (in_byte[7:4] == LEAD3_TAG) begin
      code_nxt = {17'd0, in_byte[3:0]};
      pend_nxt = PEND_TWO;
      four_nxt = 1'b0;
    end else if (in_byte[7:3] == LEAD4_TAG) begin
      code_nxt = {18'd0, in_byte[2:0]};
      pend_nxt = PEND_THREE;
      four_nxt = 1'b1;
    end else begin
      // stray continuation or invalid lead
      dec.cnt     = 2'd1;
      dec.data[0] = ERR_BYTE;
      dec.last    = 1'b1;
      dec.err     = 1'b1;
    end
  end

  // group register: load a new group or hand its front byte on
  always_comb begin
    grp_nxt = grp_r;
    if (in_acc) begin
      grp_nxt = dec;
    end else if (out_load && (grp_r.cnt != 2'd0)) begin
      grp_nxt.cnt  = grp_r.cnt - 2'd1;
      grp_nxt.data = {8'h00, grp_r.data[MAX_GROUP-1:1]};
    end
  end

  // output register fed from the front of the group
  always_comb begin
    out_valid_nxt = out_valid_r;
    out_byte_nxt  = out_byte_r;
    out_last_nxt  = out_last_r;
    out_err_nxt   = out_err_r;
    if (out_load) begin
      out_valid_nxt = (grp_r.cnt != 2'd0);
      out_byte_nxt  = grp_r.data[0];
      out_last_nxt  = grp_r.last && (grp_r.cnt == 2'd1);
      out_err_nxt   = grp_r.err;
    end
  end

  always_ff @(posedge clk) begin
    // payload, no reset needed
    grp_r.data <= grp_nxt.data;
    grp_r.last <= grp_nxt.last;
    grp_r.err  <= grp_nxt.err;
    out_byte_r <= out_byte_nxt;
    out_last_r <= out_last_nxt;
    out_err_r  <= out_err_nxt;
    if (!rst_n) begin
      code_r      <= '0;
      pend_r      <= PEND_IDLE;
      four_r      <= 1'b0;
      grp_r.cnt   <= 2'd0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_acc) begin
        code_r <= code_nxt;
        pend_r <= pend_nxt;
        four_r <= four_nxt;
      end
      grp_r.cnt   <= grp_nxt.cnt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid   = out_valid_r;
  assign out_byte    = out_byte_r;
  assign out_is_last = out_last_r;
  assign out_error   = out_err_r;

endmodule

// File: rtl/u2ub_checker.sv
// port-level checks for the utf8 decoder core, bound to the top level
// depends on u2ub_pkg and utf8_to_unicode_bytes_core_defines.svh
`include "utf8_to_unicode_bytes_core_defines.svh"

module u2ub_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_stall,
  input logic [7:0] in_byte,
  input logic       out_valid,
  input logic       out_stall,
  input logic [7:0] out_byte,
  input logic       out_is_last,
  input logic       out_error
);
  import u2ub_pkg::*;

  logic       err_item, err_ok, end_item, out_wait, in_wait;
  logic [9:0] out_pay;

  assign err_item = out_valid && out_error;
  assign err_ok   = out_is_last && (out_byte == ERR_BYTE);
  assign end_item = out_valid && out_is_last && !out_error;
  assign out_wait = out_valid && out_stall;
  assign in_wait  = in_valid && in_stall;
  assign out_pay  = {out_byte, out_is_last, out_error};

  // error item is a lone zero byte that closes the result
  `U2UB_ASSERT(a_err_form, clk, rst_n, err_item |-> err_ok, "error item malformed")

  // a closing item without error is the terminator low byte
  `U2UB_ASSERT(a_term_lo, clk, rst_n, end_item |-> (out_byte == TERM_LO), "bad terminator")

  // a stalled result holds
  `U2UB_ASSERT(a_out_hold, clk, rst_n, out_wait |=> (out_valid && $stable(out_pay)), "result moved")

  // a stalled input item holds
  `U2UB_ASSERT(a_in_hold, clk, rst_n, in_wait |=> (in_valid && $stable(in_byte)), "input moved")

  // reset empties the result side
  `U2UB_ASSERT_ALWAYS(a_rst_empty, clk, !rst_n |=> !out_valid, "result valid after reset")

endmodule

bind utf8_to_unicode_bytes_core u2ub_checker u_chk (.*);
